// File: hw/rtl/bfpf8_pkg.sv
// Shared types and constants of the binary frame parser with 8-bit Fletcher checksum.
package bfpf8_pkg;

  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;
  localparam logic [7:0] TextStart  = 8'h24;
  localparam logic [7:0] LineFeed   = 8'h0A;

  localparam logic [15:0] MaxLenReset = 16'd1024;

  typedef enum logic [3:0] {
    PhHunt    = 4'd0,
    PhSkip    = 4'd1,
    PhSync2   = 4'd2,
    PhClass   = 4'd3,
    PhId      = 4'd4,
    PhLenLo   = 4'd5,
    PhLenHi   = 4'd6,
    PhPayload = 4'd7,
    PhCkA     = 4'd8,
    PhCkB     = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindOk      = 2'd1,
    KindBad     = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
  } result_t;

endpackage

// File: hw/rtl/bfpf8_front.sv
// Front end: frame state machine that classifies each received byte into a result word or none.
module bfpf8_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [15:0]       max_len_i,
  output logic              res_valid_o,
  output bfpf8_pkg::result_t res_o
);

  bfpf8_pkg::phase_e phase_q, phase_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] len_q, len_d;
  logic [15:0] seen_q, seen_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;

  logic [7:0]  acc_a;
  logic [7:0]  acc_b;
  logic [7:0]  new_a;
  logic [15:0] new_len;
  logic [15:0] seen_inc;
  logic        emit;
  bfpf8_pkg::kind_e kind;
  logic [7:0]  data;
  logic [15:0] index;

  always_comb begin
    // Running sums start from zero on the class byte.
    acc_a = (phase_q == bfpf8_pkg::PhClass) ? 8'd0 : sum_a_q;
    acc_b = (phase_q == bfpf8_pkg::PhClass) ? 8'd0 : sum_b_q;
    new_a = acc_a + rx_byte_i;
  end

  assign new_len  = {rx_byte_i, len_lo_q};
  assign seen_inc = seen_q + 16'd1;

  always_comb begin
    phase_d  = phase_q;
    class_d  = class_q;
    id_d     = id_q;
    len_lo_d = len_lo_q;
    len_d    = len_q;
    seen_d   = seen_q;
    sum_a_d  = sum_a_q;
    sum_b_d  = sum_b_q;
    emit     = 1'b0;
    kind     = bfpf8_pkg::KindPayload;
    data     = 8'd0;
    index    = 16'd0;
    case (phase_q)
      bfpf8_pkg::PhSkip: begin
        if (rx_byte_i == bfpf8_pkg::LineFeed) begin
          phase_d = bfpf8_pkg::PhHunt;
        end
      end
      bfpf8_pkg::PhSync2: begin
        if (rx_byte_i == bfpf8_pkg::SyncSecond) begin
          phase_d = bfpf8_pkg::PhClass;
        end else begin
          phase_d = (rx_byte_i == bfpf8_pkg::SyncFirst) ? bfpf8_pkg::PhSync2
                                                        : bfpf8_pkg::PhHunt;
        end
      end
      bfpf8_pkg::PhClass: begin
        class_d = rx_byte_i;
        sum_a_d = new_a;
        sum_b_d = acc_b + new_a;
        phase_d = bfpf8_pkg::PhId;
      end
      bfpf8_pkg::PhId: begin
        id_d    = rx_byte_i;
        sum_a_d = new_a;
        sum_b_d = acc_b + new_a;
        phase_d = bfpf8_pkg::PhLenLo;
      end
      bfpf8_pkg::PhLenLo: begin
        len_lo_d = rx_byte_i;
        sum_a_d  = new_a;
        sum_b_d  = acc_b + new_a;
        phase_d  = bfpf8_pkg::PhLenHi;
      end
      bfpf8_pkg::PhLenHi: begin
        sum_a_d = new_a;
        sum_b_d = acc_b + new_a;
        len_d   = new_len;
        seen_d  = 16'd0;
        if (new_len > max_len_i) begin
          // Oversized frame: the low length byte becomes the new sync candidate.
          phase_d = (len_lo_q == bfpf8_pkg::SyncFirst) ? bfpf8_pkg::PhSync2
                                                       : bfpf8_pkg::PhHunt;
        end else if (new_len == 16'd0) begin
          phase_d = bfpf8_pkg::PhCkA;
        end else begin
          phase_d = bfpf8_pkg::PhPayload;
        end
      end
      bfpf8_pkg::PhPayload: begin
        sum_a_d = new_a;
        sum_b_d = acc_b + new_a;
        seen_d  = seen_inc;
        if (seen_inc >= len_q) begin
          phase_d = bfpf8_pkg::PhCkA;
        end
        emit  = 1'b1;
        kind  = bfpf8_pkg::KindPayload;
        data  = rx_byte_i;
        index = seen_q;
      end
      bfpf8_pkg::PhCkA: begin
        if (rx_byte_i != sum_a_q) begin
          phase_d = (rx_byte_i == bfpf8_pkg::SyncFirst) ? bfpf8_pkg::PhSync2
                                                        : bfpf8_pkg::PhHunt;
          emit    = 1'b1;
          kind    = bfpf8_pkg::KindBad;
        end else begin
          phase_d = bfpf8_pkg::PhCkB;
        end
      end
      bfpf8_pkg::PhCkB: begin
        emit = 1'b1;
        if (rx_byte_i != sum_b_q) begin
          phase_d = (rx_byte_i == bfpf8_pkg::SyncFirst) ? bfpf8_pkg::PhSync2
                                                        : bfpf8_pkg::PhHunt;
          kind    = bfpf8_pkg::KindBad;
        end else begin
          phase_d = bfpf8_pkg::PhHunt;
          kind    = bfpf8_pkg::KindOk;
        end
      end
      default: begin
        if (rx_byte_i == bfpf8_pkg::TextStart) begin
          phase_d = bfpf8_pkg::PhSkip;
        end else begin
          phase_d = (rx_byte_i == bfpf8_pkg::SyncFirst) ? bfpf8_pkg::PhSync2
                                                        : bfpf8_pkg::PhHunt;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= bfpf8_pkg::PhHunt;
      class_q  <= 8'd0;
      id_q     <= 8'd0;
      len_lo_q <= 8'd0;
      len_q    <= 16'd0;
      seen_q   <= 16'd0;
      sum_a_q  <= 8'd0;
      sum_b_q  <= 8'd0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      class_q  <= class_d;
      id_q     <= id_d;
      len_lo_q <= len_lo_d;
      len_q    <= len_d;
      seen_q   <= seen_d;
      sum_a_q  <= sum_a_d;
      sum_b_q  <= sum_b_d;
    end
  end

  // The frame fields come from the registered state, as the class and length
  // registers never change on a byte that emits a result.
  assign res_valid_o          = accept_i && emit;
  assign res_o.kind           = kind;
  assign res_o.msg_class      = class_q;
  assign res_o.msg_id         = id_q;
  assign res_o.payload_length = len_q;
  assign res_o.data_byte      = data;
  assign res_o.byte_index     = index;

endmodule

// File: hw/rtl/bfpf8_queue.sv
// Result queue between the parser and the result port, with a registered head word.
module bfpf8_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  bfpf8_pkg::result_t wr_data_i,
  input  logic               rd_en_i,
  output bfpf8_pkg::result_t rd_data_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bfpf8_pkg::result_t mem_q [Depth];
  bfpf8_pkg::result_t head_q;
  logic               head_valid_q, head_valid_d;
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  logic load;
  logic from_mem;
  logic bypass;
  logic to_mem;

  always_comb begin
    load     = !head_valid_q || rd_en_i;
    from_mem = load && (cnt_q != '0);
    bypass   = load && (cnt_q == '0) && wr_en_i;
    to_mem   = wr_en_i && !bypass;

    cnt_d = cnt_q;
    if (to_mem && !from_mem) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (from_mem && !to_mem) begin
      cnt_d = cnt_q - CntW'(1);
    end

    wr_ptr_d = wr_ptr_q;
    if (to_mem) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    rd_ptr_d = rd_ptr_q;
    if (from_mem) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end

    head_valid_d = head_valid_q;
    if (load) begin
      head_valid_d = from_mem || bypass;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      cnt_q        <= '0;
    end else begin
      head_valid_q <= head_valid_d;
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (to_mem) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
    if (from_mem) begin
      head_q <= mem_q[rd_ptr_q];
    end else if (bypass) begin
      head_q <= wr_data_i;
    end
  end

  assign rd_data_o = head_q;
  assign empty_o   = !head_valid_q;
  assign full_o    = (cnt_q == CntW'(Depth));

endmodule

// File: hw/rtl/binary_frame_parser_fletcher8_core.sv
// Top level of the receive-side binary frame parser with 8-bit Fletcher checksum.
// The block takes one received byte per word on the push side and hunts for the
// sync pair 0xB5 0x62, skipping text lines that start with '$' while hunting. It
// then reads class, id, a little-endian length and the payload, handing each
// payload byte out as a result word, and closes the frame with a checksum-ok or
// checksum-bad word. Frames longer than the max_payload_length register are
// dropped silently. A front parser handles each byte as it is accepted and
// pushes at most one result word into a queue of QueueDepth words plus a
// registered head word, so the input side sustains one byte per clock as long as
// the result side pops; full rises only when the queue has QueueDepth words
// waiting behind the head word. Results reach the output ports from the
// registered head word of the queue. The configuration channel is always ready;
// write the register only while the block is idle.
module binary_frame_parser_fletcher8_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input byte channel.
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  // Result channel.
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  msg_class_o,
  output logic [7:0]  msg_id_o,
  output logic [15:0] payload_length_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_index_o,
  // Configuration channel for max_payload_length.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0]        max_len_q;
  logic               in_accept;
  logic               res_valid;
  bfpf8_pkg::result_t res;
  bfpf8_pkg::result_t head;

  // The configuration register resets to the default limit of 1024 bytes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= bfpf8_pkg::MaxLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  assign in_accept = push && !full;

  bfpf8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .rx_byte_i   (rx_byte_i),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // The queue decouples the parser from a stalled result consumer.
  bfpf8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_valid),
    .wr_data_i (res),
    .rd_en_i   (pop && !empty),
    .rd_data_o (head),
    .full_o    (full),
    .empty_o   (empty)
  );

  assign kind_o           = head.kind;
  assign msg_class_o      = head.msg_class;
  assign msg_id_o         = head.msg_id;
  assign payload_length_o = head.payload_length;
  assign data_byte_o      = head.data_byte;
  assign byte_index_o     = head.byte_index;

endmodule

// File: tb/bfpf8_result_checker.sv
// Checker that predicts the result words of the frame parser and scores the ones it hands out.
module bfpf8_result_checker
  import bfpf8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        pop_i,
  input  logic        empty_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  msg_class_i,
  input  logic [7:0]  msg_id_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] byte_index_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          payload_words_o,
  output int          good_frames_o,
  output int          bad_frames_o
);

  logic [15:0] len_limit;
  phase_e      ph;
  logic [7:0]  cur_class;
  logic [7:0]  cur_id;
  logic [7:0]  len_lo;
  logic [15:0] cur_len;
  logic [15:0] seen;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  result_t     expected_words[$];

  // A byte that ends a frame attempt is looked at again as a possible first sync byte.
  function automatic phase_e resync_phase(input logic [7:0] b);
    return (b == SyncFirst) ? PhSync2 : PhHunt;
  endfunction

  task automatic add_sum(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    result_t     w;
    bit          has_word;
    logic [15:0] idx;
    w = '0;
    has_word = 1'b0;
    case (ph)
      PhSkip: begin
        if (b == LineFeed) ph = PhHunt;
      end
      PhSync2: begin
        ph = (b == SyncSecond) ? PhClass : resync_phase(b);
      end
      PhClass: begin
        sum_a = '0;
        sum_b = '0;
        cur_class = b;
        add_sum(b);
        ph = PhId;
      end
      PhId: begin
        cur_id = b;
        add_sum(b);
        ph = PhLenLo;
      end
      PhLenLo: begin
        len_lo = b;
        add_sum(b);
        ph = PhLenHi;
      end
      PhLenHi: begin
        add_sum(b);
        cur_len = {b, len_lo};
        seen = '0;
        if (cur_len > len_limit) ph = resync_phase(len_lo);
        else ph = (cur_len == 16'd0) ? PhCkA : PhPayload;
      end
      PhPayload: begin
        add_sum(b);
        idx = seen;
        seen = seen + 16'd1;
        if (seen >= cur_len) ph = PhCkA;
        has_word = 1'b1;
        w.kind = KindPayload;
        w.data_byte = b;
        w.byte_index = idx;
      end
      PhCkA: begin
        if (b != sum_a) begin
          ph = resync_phase(b);
          has_word = 1'b1;
          w.kind = KindBad;
        end else begin
          ph = PhCkB;
        end
      end
      PhCkB: begin
        has_word = 1'b1;
        if (b != sum_b) begin
          ph = resync_phase(b);
          w.kind = KindBad;
        end else begin
          ph = PhHunt;
          w.kind = KindOk;
        end
      end
      default: begin
        ph = (b == TextStart) ? PhSkip : resync_phase(b);
      end
    endcase
    if (has_word) begin
      w.msg_class = cur_class;
      w.msg_id = cur_id;
      w.payload_length = cur_len;
      expected_words.push_back(w);
    end
  endtask

  task automatic check_field(input string name, input int unsigned expv, input int unsigned actv);
    if (expv != actv) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expv, actv);
      fail_count_o++;
    end
  endtask

  task automatic score_word();
    result_t w;
    if (expected_words.size() == 0) begin
      $error("result word of kind %0d arrived with no expected word waiting", kind_i);
      fail_count_o++;
    end else begin
      w = expected_words.pop_front();
      check_field("kind", w.kind, kind_i);
      check_field("msg_class", w.msg_class, msg_class_i);
      check_field("msg_id", w.msg_id, msg_id_i);
      check_field("payload_length", w.payload_length, payload_length_i);
      check_field("data_byte", w.data_byte, data_byte_i);
      check_field("byte_index", w.byte_index, byte_index_i);
      case (w.kind)
        KindPayload: payload_words_o++;
        KindOk:      good_frames_o++;
        default:     bad_frames_o++;
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_limit = MaxLenReset;
      ph = PhHunt;
      cur_class = '0;
      cur_id = '0;
      len_lo = '0;
      cur_len = '0;
      seen = '0;
      sum_a = '0;
      sum_b = '0;
      expected_words.delete();
      fail_count_o = 0;
      pending_o = 0;
      payload_words_o = 0;
      good_frames_o = 0;
      bad_frames_o = 0;
    end else begin
      if (pop_i && !empty_i) score_word();
      if (push_i && !full_i) predict_byte(rx_byte_i);
      if (cfg_valid_i && cfg_ready_i) len_limit = cfg_data_i;
      pending_o = expected_words.size();
    end
  end

endmodule

// File: tb/binary_frame_parser_fletcher8_core_tb.sv
// Testbench top: feeds bytes, drains result words and writes the length limit of the parser.
module binary_frame_parser_fletcher8_core_tb;
  import bfpf8_pkg::*;

  localparam int ClkHalf      = 6;
  localparam int ResetCycles  = 6;
  localparam int IdleLimit    = 3000;
  localparam int LongHold     = 400;
  localparam int SettleCycles = 4;
  localparam int RandomBytes  = 1280;

  typedef enum int {FrGood, FrBadA, FrBadB, FrOverLen} frame_flavor_e;
  typedef enum int {SinkFree, SinkCoin, SinkSparse, SinkPeriodic} sink_mode_e;

  // Every input of the block holds a known value from time zero on.
  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        pop       = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data  = 16'h0000;

  logic        full;
  logic        empty;
  logic        cfg_ready;
  logic [1:0]  kind;
  logic [7:0]  msg_class;
  logic [7:0]  msg_id;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;

  int fail_count;
  int pending;
  int payload_words;
  int good_frames;
  int bad_frames;

  // Bytes waiting to be offered, oldest first. The main process fills it and
  // the byte source drains it one word per push handshake.
  logic [7:0] tx_bytes[$];
  int         bytes_queued;
  int         bytes_sent;
  int         settings_used;
  int         max_len;
  bit         hold_off_req;

  binary_frame_parser_fletcher8_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .rx_byte_i        (rx_byte),
    .empty            (empty),
    .pop              (pop),
    .kind_o           (kind),
    .msg_class_o      (msg_class),
    .msg_id_o         (msg_id),
    .payload_length_o (payload_length),
    .data_byte_o      (data_byte),
    .byte_index_o     (byte_index),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data)
  );

  bfpf8_result_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .rx_byte_i        (rx_byte),
    .pop_i            (pop),
    .empty_i          (empty),
    .kind_i           (kind),
    .msg_class_i      (msg_class),
    .msg_id_i         (msg_id),
    .payload_length_i (payload_length),
    .data_byte_i      (data_byte),
    .byte_index_i     (byte_index),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .payload_words_o  (payload_words),
    .good_frames_o    (good_frames),
    .bad_frames_o     (bad_frames)
  );

  always #ClkHalf clk_i = ~clk_i;

  task automatic queue_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  // A wrong checksum byte. Now and then it is a first sync byte, so that the
  // restart after a mismatch lands in the second-sync state.
  function automatic logic [7:0] pick_wrong(input logic [7:0] good);
    logic [7:0] v;
    if (good != SyncFirst && $urandom_range(0, 3) == 0) v = SyncFirst;
    else v = good ^ 8'($urandom_range(1, 255));
    return v;
  endfunction

  // Builds one frame with random payload. The checksum is worked out here only
  // to make good frames and well-aimed bad ones; scoring is left to the checker.
  // An over-length frame stops after its header, since the parser drops it there.
  task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input frame_flavor_e flavor,
                             input bit lead_sync = 1'b1);
    logic [7:0] body[$];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    body = '{cls, id, len[7:0], len[15:8]};
    if (flavor != FrOverLen) begin
      for (int i = 0; i < int'(len); i++) body.push_back(8'($urandom_range(0, 255)));
    end
    ck_a = '0;
    ck_b = '0;
    foreach (body[i]) begin
      ck_a = ck_a + body[i];
      ck_b = ck_b + ck_a;
    end
    if (lead_sync) queue_byte(SyncFirst);
    queue_byte(SyncSecond);
    foreach (body[i]) queue_byte(body[i]);
    case (flavor)
      FrGood: begin
        queue_byte(ck_a);
        queue_byte(ck_b);
      end
      FrBadA: queue_byte(pick_wrong(ck_a));
      FrBadB: begin
        queue_byte(ck_a);
        queue_byte(pick_wrong(ck_b));
      end
      default: ;
    endcase
  endtask

  // A text line: '$', a few bytes that are not a line feed, then the line feed.
  task automatic queue_text_line();
    logic [7:0] b;
    queue_byte(TextStart);
    repeat ($urandom_range(0, 6)) begin
      b = 8'($urandom_range(0, 255));
      if (b == LineFeed) b = LineFeed + 8'd1;
      queue_byte(b);
    end
    queue_byte(LineFeed);
  endtask

  // Mostly well-formed frames with short payloads, since only those reach the
  // payload and checksum states; the rest is bad checksums, dropped frames,
  // text lines and loose noise bytes.
  task automatic queue_random_item();
    int          roll;
    int          cap;
    logic [15:0] len;
    logic [15:0] alt;
    roll = $urandom_range(0, 99);
    cap = (max_len < 12) ? max_len : 12;
    len = 16'($urandom_range(0, cap));
    if (max_len <= 48 && $urandom_range(0, 7) == 0) len = 16'(max_len);
    if (roll < 56) begin
      queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, FrGood);
    end else if (roll < 66) begin
      queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, FrBadA);
    end else if (roll < 76) begin
      queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, FrBadB);
    end else if (roll < 84 && max_len < 65535) begin
      // Over the limit; sometimes with a low length byte that is a first sync byte.
      len = 16'($urandom_range(max_len + 1, 65535));
      alt = {len[15:8], SyncFirst};
      if ($urandom_range(0, 2) == 0 && alt > max_len) len = alt;
      queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, FrOverLen);
    end else if (roll < 92) begin
      queue_text_line();
    end else begin
      repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Keeps the byte queue short so that stimulus and receiver stalls interleave.
  task automatic run_random(input int n);
    int target;
    target = bytes_queued + n;
    while (bytes_queued < target) begin
      queue_random_item();
      while (tx_bytes.size() > 32) @(negedge clk_i);
    end
  endtask

  // The block is idle once every byte is in, every expected word is out, and a
  // few cycles have passed for a byte that caused no word. Checker state is
  // read on the falling edge, well away from its update.
  task automatic wait_idle();
    do @(negedge clk_i); while (tx_bytes.size() != 0 || push || pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_max_length(input logic [15:0] v);
    wait_idle();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_len = v;
    settings_used++;
  endtask

  // Byte source: bursts of random length with random gaps, some of them zero,
  // so that long stretches run without idling. A word that meets full stays on
  // the port unchanged until it is taken.
  initial begin : byte_source
    int burst_left;
    int gap_left;
    burst_left = 0;
    gap_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (push && !full) begin
        void'(tx_bytes.pop_front());
        bytes_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 16);
      end else if (!push && gap_left > 0) begin
        gap_left--;
      end
      if (gap_left == 0 && burst_left == 0) burst_left = $urandom_range(1, 40);
      if (gap_left == 0 && tx_bytes.size() != 0) begin
        push <= 1'b1;
        rx_byte <= tx_bytes[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result sink: switches between stall patterns of its own, each for a random
  // stretch. On request it stops popping for a long hold, which lets the
  // result queue fill and pushes the block into raising full.
  initial begin : result_sink
    sink_mode_e mode;
    int         mode_left;
    int         hold_left;
    mode = SinkFree;
    mode_left = 0;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req && hold_left == 0) begin
        hold_left = LongHold;
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          SinkFree:   pop <= 1'b1;
          SinkCoin:   pop <= 1'($urandom_range(0, 1));
          SinkSparse: pop <= ($urandom_range(0, 3) == 0);
          default:    pop <= (mode_left % 3 != 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run when no word has moved on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no word moved for %0d cycles.", IdleLimit);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    bytes_queued = 0;
    bytes_sent = 0;
    settings_used = 0;
    hold_off_req = 1'b0;
    max_len = MaxLenReset;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A text line whose body holds a sync pair, which must be skipped.
    queue_byte(TextStart);
    queue_byte(SyncFirst);
    queue_byte(SyncSecond);
    queue_byte(LineFeed);
    // A failed second sync on '$': the '$' is not taken as the start of a text line.
    queue_byte(SyncFirst);
    queue_byte(TextStart);
    // A repeated first sync byte, then a zero-length good frame with extreme class and id.
    queue_byte(SyncFirst);
    queue_frame(8'hFF, 8'h00, 16'd0, FrGood);
    // One payload byte and a wrong checksum A, so checksum B is never waited for.
    queue_frame(8'h00, 8'hFF, 16'd1, FrBadA);
    // Over the limit with a low length byte of 0xB5: the parser restarts on it,
    // so the next frame begins straight with its second sync byte.
    queue_frame(8'h12, 8'h34, 16'hFFB5, FrOverLen);
    queue_frame(8'h80, 8'h7F, 16'd2, FrBadB, 1'b0);

    run_random(RandomBytes / 6);

    // No limit at all. Here the sink holds off for a long stretch while a long
    // frame keeps the source offering words, so that full must rise.
    write_max_length(16'hFFFF);
    hold_off_req = 1'b1;
    queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd90, FrGood);
    run_random(RandomBytes / 6);

    // Only zero-length frames pass; every other length is dropped.
    write_max_length(16'd0);
    run_random(RandomBytes / 6);

    write_max_length(16'd5);
    run_random(RandomBytes / 6);

    write_max_length(16'($urandom_range(1, 400)));
    run_random(RandomBytes / 6);

    write_max_length(MaxLenReset);
    run_random(RandomBytes / 6);

    wait_idle();
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (pending != 0) $error("%0d expected words never arrived", pending);

    $display("Run sent %0d bytes under %0d length limits, 0 and 65535 among them.",
             bytes_sent, settings_used + 1);
    $display("Scored %0d payload words, %0d good and %0d bad frame ends.",
             payload_words, good_frames, bad_frames);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
